[rtl/adsr_envelope_generator_defines.svh]
// Assertion macros shared by the envelope generator RTL.
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ADSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("adsr envelope check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define ADSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("adsr envelope check failed");

`endif

[rtl/adsr_pkg.sv]
// Package with the types, constants, microcode and helpers of the envelope generator.
package adsr_pkg;

    localparam longint TICK_PERIOD_US = 100;
    localparam longint ADC_FULL_SCALE = 4095;

    localparam int LVL_W = 26;
    typedef logic signed [LVL_W-1:0] level_t;
    localparam level_t LVL_MAX = {1'b0, {(LVL_W-1){1'b1}}};
    localparam level_t LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};

    // Slope numerator with the constant part of the divisor already divided out.
    localparam longint SLOPE_NUM = (65025 * TICK_PERIOD_US * 65536) / 3000000;
    localparam int SLOPE_W = $clog2(SLOPE_NUM + 1);
    localparam int CNT_W = $clog2(SLOPE_W);

    localparam logic [12:0] THR_RESET = 13'(ADC_FULL_SCALE / 3);

    localparam logic [1:0] PH_ATTACK  = 2'd0;
    localparam logic [1:0] PH_DECAY   = 2'd1;
    localparam logic [1:0] PH_SUSTAIN = 2'd2;
    localparam logic [1:0] PH_RELEASE = 2'd3;

    localparam logic [2:0] REG_ATTACK_PEAK    = 3'd0;
    localparam logic [2:0] REG_SUSTAIN_LEVEL  = 3'd1;
    localparam logic [2:0] REG_RELEASE_FLOOR  = 3'd2;
    localparam logic [2:0] REG_ATTACK_TIME    = 3'd3;
    localparam logic [2:0] REG_DECAY_TIME     = 3'd4;
    localparam logic [2:0] REG_RELEASE_TIME   = 3'd5;
    localparam logic [2:0] REG_GATE_THRESHOLD = 3'd6;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_DIV_INIT = 2'd1;
    localparam logic [1:0] OP_DIV_STEP = 2'd2;
    localparam logic [1:0] OP_APPLY    = 2'd3;

    localparam logic [1:0] COND_NONE     = 2'd0;
    localparam logic [1:0] COND_WAIT_IN  = 2'd1;
    localparam logic [1:0] COND_LOOP_DIV = 2'd2;
    localparam logic [1:0] COND_WAIT_OUT = 2'd3;

    localparam logic [1:0] STEP_WAIT     = 2'd0;
    localparam logic [1:0] STEP_DIV_INIT = 2'd1;
    localparam logic [1:0] STEP_DIV_LOOP = 2'd2;
    localparam logic [1:0] STEP_APPLY    = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] cond;
        logic [1:0] next;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic out_full;
    } seq_stat_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic div_init;
        logic div_step;
        logic apply;
    } seq_ctrl_t;

    function automatic ucode_t ucode_rom(input logic [1:0] addr);
        ucode_t w;
        unique case (addr)
            STEP_WAIT:     w = '{op: OP_LOAD,     cond: COND_WAIT_IN,  next: STEP_DIV_INIT};
            STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NONE,     next: STEP_DIV_LOOP};
            STEP_DIV_LOOP: w = '{op: OP_DIV_STEP, cond: COND_LOOP_DIV, next: STEP_APPLY};
            STEP_APPLY:    w = '{op: OP_APPLY,    cond: COND_WAIT_OUT, next: STEP_WAIT};
            default:       w = '{op: OP_LOAD,     cond: COND_WAIT_IN,  next: STEP_DIV_INIT};
        endcase
        return w;
    endfunction

    function automatic level_t sat_level(input logic signed [LVL_W:0] v);
        level_t r;
        if (v[LVL_W] != v[LVL_W-1]) begin
            r = v[LVL_W] ? LVL_MIN : LVL_MAX;
        end else begin
            r = v[LVL_W-1:0];
        end
        return r;
    endfunction

    function automatic level_t to_q(input logic [7:0] v);
        return {{(LVL_W-24){1'b0}}, v, 16'h0000};
    endfunction

endpackage

[rtl/adsr_div.sv]
// Serial restoring divider that turns a phase time into a per-tick slope.
module adsr_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  init,
    input  logic                  step,
    input  logic [7:0]            divisor,
    output logic                  busy,
    output adsr_pkg::level_t      slope
);

    logic [adsr_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [adsr_pkg::SLOPE_W-1:0] quo_reg, quo_next;
    logic [7:0]                   rem_reg, rem_next;
    logic [7:0]                   den_reg, den_next;
    logic [8:0]                   trial;
    logic [8:0]                   diff;
    logic                         fits;

    assign trial = {rem_reg, quo_reg[adsr_pkg::SLOPE_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (init) begin
            cnt_next = adsr_pkg::CNT_W'(adsr_pkg::SLOPE_W - 1);
            quo_next = adsr_pkg::SLOPE_W'(adsr_pkg::SLOPE_NUM);
            rem_next = 8'd0;
            den_next = divisor;
        end else if (step) begin
            quo_next = {quo_reg[adsr_pkg::SLOPE_W-2:0], fits};
            rem_next = fits ? diff[7:0] : trial[7:0];
            if (cnt_reg != '0) begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);

    always_comb begin
        if (den_reg == 8'd0) begin
            slope = adsr_pkg::LVL_MAX;
        end else if (64'(quo_reg) > 64'(adsr_pkg::LVL_MAX)) begin
            slope = adsr_pkg::LVL_MAX;
        end else begin
            slope = adsr_pkg::level_t'(quo_reg);
        end
    end

endmodule

[rtl/adsr_seq.sv]
// Microcode sequencer: step counter, control ROM and conditional jumps.
module adsr_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  adsr_pkg::seq_stat_t   stat,
    output adsr_pkg::seq_ctrl_t   ctrl
);

    logic [1:0]       pc_reg, pc_next;
    adsr_pkg::ucode_t word;
    logic             hold;

    assign word = adsr_pkg::ucode_rom(pc_reg);

    always_comb begin
        unique case (word.cond)
            adsr_pkg::COND_NONE:     hold = 1'b0;
            adsr_pkg::COND_WAIT_IN:  hold = !stat.in_valid;
            adsr_pkg::COND_LOOP_DIV: hold = stat.div_busy;
            adsr_pkg::COND_WAIT_OUT: hold = stat.out_full;
            default:                 hold = 1'b0;
        endcase
    end

    assign pc_next = hold ? pc_reg : word.next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= adsr_pkg::STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    always_comb begin
        ctrl.in_ready = (word.op == adsr_pkg::OP_LOAD);
        ctrl.load     = (word.op == adsr_pkg::OP_LOAD) && !hold;
        ctrl.div_init = (word.op == adsr_pkg::OP_DIV_INIT);
        ctrl.div_step = (word.op == adsr_pkg::OP_DIV_STEP);
        ctrl.apply    = (word.op == adsr_pkg::OP_APPLY) && !hold;
    end

endmodule

[rtl/adsr_envelope_generator.sv]
// Each input transfer runs through the divider init, serial slope divider loop and apply steps,
// and the result is registered in the apply step; no new input is taken until the wait step.
// The input is ready only in the sequencer's wait step; a held result stalls the apply step.
// Reset is synchronous and active low: phase goes to release, level to zero,
// and the configuration registers to their defaults.
`include "adsr_envelope_generator_defines.svh"

module adsr_envelope_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // gate_knob [11:0], gate_jack [23:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // level [7:0], phase [9:8], zeros [15:10]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    logic [7:0]  attack_peak_reg;
    logic [7:0]  sustain_level_reg;
    logic [7:0]  release_floor_reg;
    logic [7:0]  attack_time_reg;
    logic [7:0]  decay_time_reg;
    logic [7:0]  release_time_reg;
    logic [12:0] gate_threshold_reg;

    logic [1:0]        phase_reg, phase_next;
    adsr_pkg::level_t  level_reg, level_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_level_reg;
    logic [1:0]        out_phase_reg;

    adsr_pkg::seq_stat_t stat;
    adsr_pkg::seq_ctrl_t ctrl;

    logic [12:0]       gate_sum;
    logic              gate_on;
    logic [1:0]        phase_loaded;
    logic [7:0]        time_sel;
    logic              div_busy;
    adsr_pkg::level_t  slope;
    logic signed [adsr_pkg::LVL_W:0] level_up;
    logic signed [adsr_pkg::LVL_W:0] level_down;
    adsr_pkg::level_t  sum_sat;
    adsr_pkg::level_t  diff_sat;
    adsr_pkg::level_t  floor_q;
    adsr_pkg::level_t  level_new;
    logic [1:0]        phase_new;
    logic [7:0]        level_field;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_peak_reg    <= 8'd255;
            sustain_level_reg  <= 8'd128;
            release_floor_reg  <= 8'd0;
            attack_time_reg    <= 8'd64;
            decay_time_reg     <= 8'd64;
            release_time_reg   <= 8'd64;
            gate_threshold_reg <= adsr_pkg::THR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                adsr_pkg::REG_ATTACK_PEAK:    attack_peak_reg    <= cfg_data[7:0];
                adsr_pkg::REG_SUSTAIN_LEVEL:  sustain_level_reg  <= cfg_data[7:0];
                adsr_pkg::REG_RELEASE_FLOOR:  release_floor_reg  <= cfg_data[7:0];
                adsr_pkg::REG_ATTACK_TIME:    attack_time_reg    <= cfg_data[7:0];
                adsr_pkg::REG_DECAY_TIME:     decay_time_reg     <= cfg_data[7:0];
                adsr_pkg::REG_RELEASE_TIME:   release_time_reg   <= cfg_data[7:0];
                adsr_pkg::REG_GATE_THRESHOLD: gate_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign stat.in_valid = s_axis_tvalid;
    assign stat.div_busy = div_busy;
    assign stat.out_full = out_valid_reg && !m_axis_tready;

    adsr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    assign s_axis_tready = ctrl.in_ready;

    assign gate_sum = {1'b0, s_axis_tdata[11:0]} + {1'b0, s_axis_tdata[23:12]};
    assign gate_on  = (gate_sum > gate_threshold_reg);

    always_comb begin
        if (!gate_on) begin
            phase_loaded = adsr_pkg::PH_RELEASE;
        end else if (phase_reg == adsr_pkg::PH_RELEASE) begin
            phase_loaded = adsr_pkg::PH_ATTACK;
        end else begin
            phase_loaded = phase_reg;
        end
    end

    always_comb begin
        case (phase_reg)
            adsr_pkg::PH_ATTACK: time_sel = attack_time_reg;
            adsr_pkg::PH_DECAY:  time_sel = decay_time_reg;
            default:             time_sel = release_time_reg;
        endcase
    end

    adsr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .init    (ctrl.div_init),
        .step    (ctrl.div_step),
        .divisor (time_sel),
        .busy    (div_busy),
        .slope   (slope)
    );

    assign level_up   = {level_reg[adsr_pkg::LVL_W-1], level_reg} + {1'b0, slope};
    assign level_down = {level_reg[adsr_pkg::LVL_W-1], level_reg} - {1'b0, slope};
    assign sum_sat    = adsr_pkg::sat_level(level_up);
    assign diff_sat   = adsr_pkg::sat_level(level_down);
    assign floor_q    = adsr_pkg::to_q(release_floor_reg);

    always_comb begin
        level_new = level_reg;
        phase_new = phase_reg;
        unique case (phase_reg)
            adsr_pkg::PH_ATTACK: begin
                level_new = sum_sat;
                if (sum_sat > adsr_pkg::to_q(attack_peak_reg)) begin
                    phase_new = adsr_pkg::PH_DECAY;
                end
            end
            adsr_pkg::PH_DECAY: begin
                level_new = diff_sat;
                if (diff_sat < adsr_pkg::to_q(sustain_level_reg)) begin
                    phase_new = adsr_pkg::PH_SUSTAIN;
                end
            end
            adsr_pkg::PH_SUSTAIN: begin
                level_new = adsr_pkg::to_q(sustain_level_reg);
            end
            default: begin
                level_new = (diff_sat < floor_q) ? floor_q : diff_sat;
            end
        endcase
    end

    always_comb begin
        if (level_new[adsr_pkg::LVL_W-1]) begin
            level_field = 8'd0;
        end else if (level_new[24]) begin
            level_field = 8'd255;
        end else begin
            level_field = level_new[23:16];
        end
    end

    always_comb begin
        phase_next = phase_reg;
        level_next = level_reg;
        if (ctrl.load) begin
            phase_next = phase_loaded;
        end else if (ctrl.apply) begin
            phase_next = phase_new;
            level_next = level_new;
        end
    end

    assign out_valid_next = ctrl.apply || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= adsr_pkg::PH_RELEASE;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
        if (ctrl.apply) begin
            out_level_reg <= level_field;
            out_phase_reg <= phase_new;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_phase_reg, out_level_reg};

    `ADSR_ASSERT_NOW(a_no_overwrite, ctrl.apply, !(out_valid_reg && !m_axis_tready))
    `ADSR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ADSR_ASSERT_NOW(a_release_clamp, ctrl.apply && phase_new == adsr_pkg::PH_RELEASE,
                     level_new >= floor_q)

endmodule
